// File: hw/rtl/toa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toa_pkg
// Shared types, widths, register codes and the arctangent table for the
// tilt orientation to aim block.
// ----------------------------------------------------------------------------
package toa_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int ATAN_ITER_DEF = 16;

  localparam int AXIS_W = 16;
  localparam int AIM_W  = 16;
  localparam int CFG_W  = 15;
  localparam int CFG_IDX_W = 2;
  localparam int FRAMES_W = 10;
  localparam int RANGE_W  = 15;
  localparam int WAIT_W   = 11;

  localparam int ACC_W = 34;          // sum of three 16x16 products
  localparam int P_W   = 27;          // rotated axis component after >> 6
  localparam int SQ_W  = 2 * P_W;     // sum of squares
  localparam int CW    = 32;          // CORDIC x / y
  localparam int ZW    = 35;          // CORDIC angle, Q5.30
  localparam int TAB_IDX_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_FRAMES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_RANGE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_RANGE    = 2'd3;

  localparam logic [FRAMES_W-1:0] WAIT_FRAMES_RST    = 10'd60;
  localparam logic [FRAMES_W-1:0] LOCKOUT_FRAMES_RST = 10'd60;
  localparam logic [RANGE_W-1:0]  YAW_RANGE_RST      = 15'd6434;
  localparam logic [RANGE_W-1:0]  PITCH_RANGE_RST    = 15'd6434;

  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_CAPTURE = 1'b1;

  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAC,
    ST_SQ1,
    ST_SQ2,
    ST_HYP,
    ST_PCINIT,
    ST_PCITER,
    ST_YCINIT,
    ST_YCITER,
    ST_DYINIT,
    ST_DYITER,
    ST_DPINIT,
    ST_DPITER,
    ST_LEN1,
    ST_LEN2,
    ST_LSQRT,
    ST_NHINIT,
    ST_NHITER,
    ST_NVINIT,
    ST_NVITER,
    ST_OUT
  } state_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [TAB_IDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 35'sd843314856;
      5'd1:  v = 35'sd497837829;
      5'd2:  v = 35'sd263043836;
      5'd3:  v = 35'sd133525158;
      5'd4:  v = 35'sd67021686;
      5'd5:  v = 35'sd33543515;
      5'd6:  v = 35'sd16775850;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194282;
      5'd9:  v = 35'sd2097149;
      5'd10: v = 35'sd1048575;
      5'd11: v = 35'sd524287;
      5'd12: v = 35'sd262143;
      5'd13: v = 35'sd131071;
      5'd14: v = 35'sd65535;
      5'd15: v = 35'sd32767;
      5'd16: v = 35'sd16383;
      5'd17: v = 35'sd8191;
      5'd18: v = 35'sd4095;
      5'd19: v = 35'sd2047;
      5'd20: v = 35'sd1023;
      5'd21: v = 35'sd511;
      5'd22: v = 35'sd255;
      5'd23: v = 35'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/toa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toa_in_if
// Input channel: one frame or reference capture per transaction.
// ----------------------------------------------------------------------------
interface toa_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic sensor_valid;
  logic recenter_press;
  logic signed [toa_pkg::AXIS_W-1:0] axis_x_x;
  logic signed [toa_pkg::AXIS_W-1:0] axis_x_y;
  logic signed [toa_pkg::AXIS_W-1:0] axis_x_z;
  logic signed [toa_pkg::AXIS_W-1:0] axis_y_x;
  logic signed [toa_pkg::AXIS_W-1:0] axis_y_y;
  logic signed [toa_pkg::AXIS_W-1:0] axis_y_z;
  logic signed [toa_pkg::AXIS_W-1:0] axis_z_x;
  logic signed [toa_pkg::AXIS_W-1:0] axis_z_y;
  logic signed [toa_pkg::AXIS_W-1:0] axis_z_z;

  modport source (
    output valid, kind, sensor_valid, recenter_press,
           axis_x_x, axis_x_y, axis_x_z, axis_y_x, axis_y_y, axis_y_z,
           axis_z_x, axis_z_y, axis_z_z,
    input  ready
  );
  modport sink (
    input  valid, kind, sensor_valid, recenter_press,
           axis_x_x, axis_x_y, axis_x_z, axis_y_x, axis_y_y, axis_y_z,
           axis_z_x, axis_z_y, axis_z_z,
    output ready
  );
endinterface

// File: hw/rtl/toa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toa_out_if
// Result channel: aim vector and recenter flag, one per transaction.
// ----------------------------------------------------------------------------
interface toa_out_if;
  logic valid;
  logic ready;
  logic signed [toa_pkg::AIM_W-1:0] aim_horizontal;
  logic signed [toa_pkg::AIM_W-1:0] aim_vertical;
  logic recenter_started;

  modport source (
    output valid, aim_horizontal, aim_vertical, recenter_started,
    input  ready
  );
  modport sink (
    input  valid, aim_horizontal, aim_vertical, recenter_started,
    output ready
  );
endinterface

// File: hw/rtl/tilt_orientation_to_aim_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_orientation_to_aim_top
// Turns device orientation vectors into a clamped, normalized aim vector,
// with button recentering against a stored reference matrix.
// ----------------------------------------------------------------------------
// Usage:
//  in_if  : valid/ready; one transaction per frame (kind frame) or a
//           reference capture (kind capture).
//  out_if : valid/ready; exactly one result per input transaction, holding
//           the current aim and the recenter-started flag.
//  cfg_*  : write-only register port; user writes only in idle, unenforced.
// Sequence: a capture, an ignored frame or a recentering-wait frame goes
//  from idle straight to the output register. A computed frame runs the
//  matrix products, the squares, a square root, the pitch and yaw CORDIC
//  (each skipped when both of its operands are zero) and two divisions,
//  then a second square root and two more divisions when the aim vector
//  needs normalizing. The square roots work on SQW bits, where
//  SQW = max(54, 2*FRAC_BITS+18). The sequencer returns to idle before
//  the next transaction is taken. One shared multiplier, square root,
//  CORDIC and divider are used in turn.
// One transaction is in work at a time; in_if.ready is high only when idle.
// A new transaction may be taken while the previous result waits; the next
//  result waits in the sequencer until out_if is free.
// Reset: no reference, no recentering, held aim zero, registers at defaults.
// ----------------------------------------------------------------------------
module tilt_orientation_to_aim_top #(
  parameter int FRAC_BITS       = toa_pkg::FRAC_BITS_DEF,
  parameter int ATAN_ITERATIONS = toa_pkg::ATAN_ITER_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  toa_in_if.sink                         in_if,
  toa_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [toa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [toa_pkg::CFG_W-1:0]      cfg_data
);

  localparam int F     = FRAC_BITS;
  localparam int PW    = toa_pkg::P_W;
  localparam int ACCW  = toa_pkg::ACC_W;
  localparam int SQIW  = toa_pkg::SQ_W;
  localparam int SQW   = (2 * F + 18 > SQIW) ? 2 * F + 18 : SQIW;
  localparam int SH    = SQW / 2;
  localparam int SRW   = SH + 3;
  localparam int CW    = toa_pkg::CW;
  localparam int ZW    = toa_pkg::ZW;
  localparam int NUMW  = F + 35;
  localparam int QW    = F + 2;
  localparam int CNT_W = $clog2(SH + 1);
  localparam int AW    = toa_pkg::AXIS_W;

  toa_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       ridx_r, ridx_nxt;
  logic [1:0]       col_r, col_nxt;
  logic [1:0]       row_r, row_nxt;
  logic signed [ACCW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0]   p_r [3];
  logic signed [PW-1:0]   p_nxt [3];
  logic signed [AW-1:0]   vz_r [3];
  logic signed [AW-1:0]   vz_nxt [3];
  logic signed [AW-1:0]   ref_r [9];
  logic signed [AW-1:0]   ref_nxt [9];
  logic [SQIW-1:0]        sq_r, sq_nxt;

  logic [SQW-1:0] sqn_r, sqn_nxt;
  logic [SRW-1:0] srem_r, srem_nxt;
  logic [SH-1:0]  sroot_r, sroot_nxt;

  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ZW-1:0] cz_r, cz_nxt, pitch_r, pitch_nxt;

  logic [NUMW-1:0] drem_r, drem_nxt, dsh_r, dsh_nxt;
  logic [QW-1:0]   dquo_r, dquo_nxt;
  logic            dneg_r, dneg_nxt;
  logic signed [QW-1:0] ah_r, ah_nxt, av_r, av_nxt;

  logic                          ref_ready_r, ref_ready_nxt;
  logic                          rec_r, rec_nxt;
  logic [toa_pkg::WAIT_W-1:0]    wait_r, wait_nxt;
  logic [toa_pkg::FRAMES_W-1:0]  lock_r, lock_nxt;
  logic signed [toa_pkg::AIM_W-1:0] held_h_r, held_h_nxt, held_v_r, held_v_nxt;
  logic                          held_st_r, held_st_nxt;

  logic [toa_pkg::FRAMES_W-1:0] wait_frames_r, lockout_frames_r;
  logic [toa_pkg::RANGE_W-1:0]  yaw_range_r, pitch_range_r;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [toa_pkg::AIM_W-1:0] out_h_r, out_h_nxt, out_v_r, out_v_nxt;
  logic                          out_st_r, out_st_nxt;

  // shared units, combinational part
  logic signed [PW-1:0]     mul_a, mul_b;
  logic signed [2*PW-1:0]   prod;
  logic                     accept, go_compute, out_load;
  logic signed [CW-1:0]     ci_x, ci_y;
  logic                     cord_zero;
  logic [SRW-1:0]           s_remt, s_trial;
  logic                     s_ge;
  logic                     d_ge;
  logic [QW-1:0]            d_q, d_qc;
  logic signed [QW-1:0]     d_res;
  logic [SQIW-1:0]          l2;
  logic                     len_big;
  logic signed [ZW-1:0]     s_ang;
  logic [ZW-1:0]            s_mag;
  logic [toa_pkg::RANGE_W-1:0] s_rng;
  logic signed [QW-1:0]     n_comp;
  logic [QW-1:0]            n_mag;
  logic                     sqrt_done, cord_done, div_done;

  assign accept   = in_if.valid && in_if.ready;
  assign out_load = (state_r == toa_pkg::ST_OUT) && (!out_valid_r || out_if.ready);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      toa_pkg::ST_MAC: begin
        mul_a = PW'(ref_r[ridx_r]);
        mul_b = PW'(vz_r[col_r]);
      end
      toa_pkg::ST_SQ1: begin
        mul_a = p_r[1];
        mul_b = p_r[1];
      end
      toa_pkg::ST_SQ2: begin
        mul_a = p_r[2];
        mul_b = p_r[2];
      end
      toa_pkg::ST_LEN1: begin
        mul_a = PW'(ah_r);
        mul_b = PW'(ah_r);
      end
      toa_pkg::ST_LEN2: begin
        mul_a = PW'(av_r);
        mul_b = PW'(av_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign l2   = sq_r + SQIW'(prod);
  assign len_big = l2 > (SQIW'(1) << (2 * F));

  // CORDIC start operands
  always_comb begin
    if (state_r == toa_pkg::ST_PCINIT) begin
      ci_y = -CW'(p_r[1]);
      ci_x = CW'(p_r[2]);
    end else begin
      ci_y = CW'(p_r[0]);
      ci_x = CW'(sroot_r);
    end
  end
  assign cord_zero = (ci_x == '0) && (ci_y == '0);

  // square root step
  assign s_remt  = {srem_r[SRW-3:0], sqn_r[SQW-1 -: 2]};
  assign s_trial = SRW'({sroot_r, 2'b01});
  assign s_ge    = s_remt >= s_trial;

  // divider step
  assign d_ge  = drem_r >= dsh_r;
  assign d_q   = {dquo_r[QW-2:0], d_ge};
  assign d_qc  = (d_q > (QW'(1) << F)) ? (QW'(1) << F) : d_q;
  assign d_res = dneg_r ? -$signed(d_qc) : $signed(d_qc);

  // divider operand selection
  assign s_ang = (state_r == toa_pkg::ST_DYINIT) ? cz_r : pitch_r;
  assign s_mag = (s_ang < 0) ? ZW'(-s_ang) : ZW'(s_ang);
  always_comb begin
    s_rng = (state_r == toa_pkg::ST_DYINIT) ? yaw_range_r : pitch_range_r;
    if (s_rng == '0) begin
      s_rng = toa_pkg::RANGE_W'(1);
    end
  end
  assign n_comp = (state_r == toa_pkg::ST_NHINIT) ? ah_r : av_r;
  assign n_mag  = (n_comp < 0) ? QW'(-n_comp) : QW'(n_comp);

  assign sqrt_done = cnt_r == CNT_W'(SH - 1);
  assign cord_done = cnt_r == CNT_W'(ATAN_ITERATIONS - 1);
  assign div_done  = cnt_r == CNT_W'(QW - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      toa_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = go_compute ? toa_pkg::ST_MAC : toa_pkg::ST_OUT;
        end
      end
      toa_pkg::ST_MAC: begin
        if (ridx_r == 4'd8) state_nxt = toa_pkg::ST_SQ1;
      end
      toa_pkg::ST_SQ1:   state_nxt = toa_pkg::ST_SQ2;
      toa_pkg::ST_SQ2:   state_nxt = toa_pkg::ST_HYP;
      toa_pkg::ST_HYP: begin
        if (sqrt_done) state_nxt = toa_pkg::ST_PCINIT;
      end
      toa_pkg::ST_PCINIT: begin
        state_nxt = cord_zero ? toa_pkg::ST_YCINIT : toa_pkg::ST_PCITER;
      end
      toa_pkg::ST_PCITER: begin
        if (cord_done) state_nxt = toa_pkg::ST_YCINIT;
      end
      toa_pkg::ST_YCINIT: begin
        state_nxt = cord_zero ? toa_pkg::ST_DYINIT : toa_pkg::ST_YCITER;
      end
      toa_pkg::ST_YCITER: begin
        if (cord_done) state_nxt = toa_pkg::ST_DYINIT;
      end
      toa_pkg::ST_DYINIT: state_nxt = toa_pkg::ST_DYITER;
      toa_pkg::ST_DYITER: begin
        if (div_done) state_nxt = toa_pkg::ST_DPINIT;
      end
      toa_pkg::ST_DPINIT: state_nxt = toa_pkg::ST_DPITER;
      toa_pkg::ST_DPITER: begin
        if (div_done) state_nxt = toa_pkg::ST_LEN1;
      end
      toa_pkg::ST_LEN1: state_nxt = toa_pkg::ST_LEN2;
      toa_pkg::ST_LEN2: begin
        state_nxt = len_big ? toa_pkg::ST_LSQRT : toa_pkg::ST_OUT;
      end
      toa_pkg::ST_LSQRT: begin
        if (sqrt_done) state_nxt = toa_pkg::ST_NHINIT;
      end
      toa_pkg::ST_NHINIT: state_nxt = toa_pkg::ST_NHITER;
      toa_pkg::ST_NHITER: begin
        if (div_done) state_nxt = toa_pkg::ST_NVINIT;
      end
      toa_pkg::ST_NVINIT: state_nxt = toa_pkg::ST_NVITER;
      toa_pkg::ST_NVITER: begin
        if (div_done) state_nxt = toa_pkg::ST_OUT;
      end
      toa_pkg::ST_OUT: begin
        if (out_load) state_nxt = toa_pkg::ST_IDLE;
      end
      default: state_nxt = toa_pkg::ST_IDLE;
    endcase
  end

  // datapath and frame control
  always_comb begin
    logic [toa_pkg::FRAMES_W-1:0] lk;
    logic [toa_pkg::WAIT_W-1:0]   wt;
    logic rc;
    logic st;
    logic cmp;
    logic signed [ACCW-1:0] asum;
    logic signed [CW-1:0] dx, dy;

    cnt_nxt = cnt_r;
    ridx_nxt = ridx_r;
    col_nxt = col_r;
    row_nxt = row_r;
    acc_nxt = acc_r;
    p_nxt = p_r;
    vz_nxt = vz_r;
    ref_nxt = ref_r;
    sq_nxt = sq_r;
    sqn_nxt = sqn_r;
    srem_nxt = srem_r;
    sroot_nxt = sroot_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cz_nxt = cz_r;
    pitch_nxt = pitch_r;
    drem_nxt = drem_r;
    dsh_nxt = dsh_r;
    dquo_nxt = dquo_r;
    dneg_nxt = dneg_r;
    ah_nxt = ah_r;
    av_nxt = av_r;
    ref_ready_nxt = ref_ready_r;
    rec_nxt = rec_r;
    wait_nxt = wait_r;
    lock_nxt = lock_r;
    held_h_nxt = held_h_r;
    held_v_nxt = held_v_r;
    held_st_nxt = held_st_r;
    go_compute = 1'b0;
    lk = '0;
    wt = '0;
    rc = 1'b0;
    st = 1'b0;
    cmp = 1'b0;
    asum = '0;
    dx = '0;
    dy = '0;

    case (state_r)
      toa_pkg::ST_IDLE: begin
        if (accept) begin
          vz_nxt[0] = in_if.axis_z_x;
          vz_nxt[1] = in_if.axis_z_y;
          vz_nxt[2] = in_if.axis_z_z;
          ridx_nxt = '0;
          col_nxt = '0;
          row_nxt = '0;
          if (in_if.kind == toa_pkg::KIND_CAPTURE) begin
            ref_nxt = '{in_if.axis_x_x, in_if.axis_x_y, in_if.axis_x_z,
                        in_if.axis_y_x, in_if.axis_y_y, in_if.axis_y_z,
                        in_if.axis_z_x, in_if.axis_z_y, in_if.axis_z_z};
            ref_ready_nxt = 1'b1;
          end else if (in_if.sensor_valid && ref_ready_r) begin
            lk = (lock_r != '0) ? lock_r - 1'b1 : lock_r;
            wt = wait_r;
            rc = rec_r;
            st = 1'b0;
            cmp = 1'b1;
            if (!rc && lk == '0 && in_if.recenter_press) begin
              rc = 1'b1;
              wt = '0;
              st = 1'b1;
            end
            if (rc) begin
              wt = wt + 1'b1;
              if (wt > toa_pkg::WAIT_W'(wait_frames_r)) begin
                ref_nxt = '{in_if.axis_x_x, in_if.axis_x_y, in_if.axis_x_z,
                            in_if.axis_y_x, in_if.axis_y_y, in_if.axis_y_z,
                            in_if.axis_z_x, in_if.axis_z_y, in_if.axis_z_z};
                rc = 1'b0;
                lk = lockout_frames_r;
              end else begin
                held_h_nxt = '0;
                held_v_nxt = '0;
                cmp = 1'b0;
              end
            end
            lock_nxt = lk;
            wait_nxt = wt;
            rec_nxt = rc;
            held_st_nxt = st;
            go_compute = cmp;
          end
        end
      end

      toa_pkg::ST_MAC: begin
        asum = ((col_r == 2'd0) ? ACCW'(0) : acc_r) + ACCW'(prod);
        acc_nxt = asum;
        ridx_nxt = ridx_r + 1'b1;
        if (col_r == 2'd2) begin
          p_nxt[row_r] = PW'(asum >>> 6);
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end

      toa_pkg::ST_SQ1: sq_nxt = SQIW'(prod);

      toa_pkg::ST_SQ2: begin
        sqn_nxt = SQW'(l2);
        srem_nxt = '0;
        sroot_nxt = '0;
        cnt_nxt = '0;
      end

      toa_pkg::ST_HYP, toa_pkg::ST_LSQRT: begin
        srem_nxt = s_ge ? s_remt - s_trial : s_remt;
        sroot_nxt = {sroot_r[SH-2:0], s_ge};
        sqn_nxt = sqn_r << 2;
        cnt_nxt = cnt_r + 1'b1;
      end

      toa_pkg::ST_PCINIT, toa_pkg::ST_YCINIT: begin
        cnt_nxt = '0;
        if (cord_zero) begin
          cz_nxt = '0;
          pitch_nxt = (state_r == toa_pkg::ST_PCINIT) ? ZW'(0) : pitch_r;
        end else if (ci_x < 0) begin
          cz_nxt = (ci_y >= 0) ? toa_pkg::PI_Q30 : -toa_pkg::PI_Q30;
          cx_nxt = -ci_x;
          cy_nxt = -ci_y;
        end else begin
          cz_nxt = '0;
          cx_nxt = ci_x;
          cy_nxt = ci_y;
        end
      end

      toa_pkg::ST_PCITER, toa_pkg::ST_YCITER: begin
        dx = cy_r >>> cnt_r;
        dy = cx_r >>> cnt_r;
        if (cy_r >= 0) begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          cz_nxt = cz_r + toa_pkg::atan_q30(toa_pkg::TAB_IDX_W'(cnt_r));
        end else begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          cz_nxt = cz_r - toa_pkg::atan_q30(toa_pkg::TAB_IDX_W'(cnt_r));
        end
        cnt_nxt = cnt_r + 1'b1;
        if (state_r == toa_pkg::ST_PCITER && cord_done) begin
          pitch_nxt = cz_nxt;
        end
      end

      toa_pkg::ST_DYINIT, toa_pkg::ST_DPINIT: begin
        drem_nxt = (NUMW'(s_mag) << F) + (NUMW'(s_rng) << 16);
        dsh_nxt = NUMW'(s_rng) << (F + 18);
        dquo_nxt = '0;
        dneg_nxt = s_ang > 0;
        cnt_nxt = '0;
      end

      toa_pkg::ST_NHINIT, toa_pkg::ST_NVINIT: begin
        drem_nxt = (NUMW'(n_mag) << (F + 8)) + NUMW'(sroot_r >> 1);
        dsh_nxt = NUMW'(sroot_r) << (F + 1);
        dquo_nxt = '0;
        dneg_nxt = n_comp < 0;
        cnt_nxt = '0;
      end

      toa_pkg::ST_DYITER, toa_pkg::ST_DPITER,
      toa_pkg::ST_NHITER, toa_pkg::ST_NVITER: begin
        drem_nxt = d_ge ? drem_r - dsh_r : drem_r;
        dsh_nxt = dsh_r >> 1;
        dquo_nxt = d_q;
        cnt_nxt = cnt_r + 1'b1;
        if (div_done) begin
          if (state_r == toa_pkg::ST_DYITER || state_r == toa_pkg::ST_NHITER) begin
            ah_nxt = d_res;
          end else begin
            av_nxt = d_res;
          end
          if (state_r == toa_pkg::ST_NVITER) begin
            held_h_nxt = toa_pkg::AIM_W'(ah_r);
            held_v_nxt = toa_pkg::AIM_W'(d_res);
          end
        end
      end

      toa_pkg::ST_LEN1: sq_nxt = SQIW'(prod);

      toa_pkg::ST_LEN2: begin
        if (len_big) begin
          sqn_nxt = SQW'(l2) << 16;
          srem_nxt = '0;
          sroot_nxt = '0;
          cnt_nxt = '0;
        end else begin
          held_h_nxt = toa_pkg::AIM_W'(ah_r);
          held_v_nxt = toa_pkg::AIM_W'(av_r);
        end
      end

      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_h_nxt = out_h_r;
    out_v_nxt = out_v_r;
    out_st_nxt = out_st_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_h_nxt = held_h_r;
      out_v_nxt = held_v_r;
      out_st_nxt = held_st_r;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= toa_pkg::ST_IDLE;
      ref_ready_r <= 1'b0;
      rec_r <= 1'b0;
      wait_r <= '0;
      lock_r <= '0;
      held_h_r <= '0;
      held_v_r <= '0;
      held_st_r <= 1'b0;
      out_valid_r <= 1'b0;
      wait_frames_r <= toa_pkg::WAIT_FRAMES_RST;
      lockout_frames_r <= toa_pkg::LOCKOUT_FRAMES_RST;
      yaw_range_r <= toa_pkg::YAW_RANGE_RST;
      pitch_range_r <= toa_pkg::PITCH_RANGE_RST;
    end else begin
      state_r <= state_nxt;
      ref_ready_r <= ref_ready_nxt;
      rec_r <= rec_nxt;
      wait_r <= wait_nxt;
      lock_r <= lock_nxt;
      held_h_r <= held_h_nxt;
      held_v_r <= held_v_nxt;
      held_st_r <= held_st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          toa_pkg::CFG_WAIT_FRAMES:    wait_frames_r <= cfg_data[toa_pkg::FRAMES_W-1:0];
          toa_pkg::CFG_LOCKOUT_FRAMES: lockout_frames_r <= cfg_data[toa_pkg::FRAMES_W-1:0];
          toa_pkg::CFG_YAW_RANGE:      yaw_range_r <= cfg_data[toa_pkg::RANGE_W-1:0];
          toa_pkg::CFG_PITCH_RANGE:    pitch_range_r <= cfg_data[toa_pkg::RANGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    ridx_r <= ridx_nxt;
    col_r <= col_nxt;
    row_r <= row_nxt;
    acc_r <= acc_nxt;
    p_r <= p_nxt;
    vz_r <= vz_nxt;
    ref_r <= ref_nxt;
    sq_r <= sq_nxt;
    sqn_r <= sqn_nxt;
    srem_r <= srem_nxt;
    sroot_r <= sroot_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    cz_r <= cz_nxt;
    pitch_r <= pitch_nxt;
    drem_r <= drem_nxt;
    dsh_r <= dsh_nxt;
    dquo_r <= dquo_nxt;
    dneg_r <= dneg_nxt;
    ah_r <= ah_nxt;
    av_r <= av_nxt;
    out_h_r <= out_h_nxt;
    out_v_r <= out_v_nxt;
    out_st_r <= out_st_nxt;
  end

  assign in_if.ready = state_r == toa_pkg::ST_IDLE;
  assign out_if.valid = out_valid_r;
  assign out_if.aim_horizontal = out_h_r;
  assign out_if.aim_vertical = out_v_r;
  assign out_if.recenter_started = out_st_r;

`ifndef SYNTHESIS
  a_rec_no_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    rec_r |-> (lock_r == '0))
    else $error("recentering active while lockout is running");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != toa_pkg::ST_IDLE))
    else $error("transaction accepted but sequencer stayed idle");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == toa_pkg::ST_OUT) && out_valid_r && !out_if.ready
      |=> (state_r == toa_pkg::ST_OUT))
    else $error("pending result dropped while output stalled");
`endif

endmodule

// File: tb/tilt_orientation_to_aim_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_orientation_to_aim_top_tb
// Self-checking bench for the tilt-to-aim block. Directed frames cover the
// axis extremes, the reverse-facing pitch cases and the recenter sequence.
// Random phases follow, each under its own register setting. A scoreboard
// predicts every result in step with the accepted transactions and checks
// each output field. Both channels idle in random bursts, and one phase
// holds the result side off long enough to stall the input.
// ----------------------------------------------------------------------------
module tilt_orientation_to_aim_top_tb;

  typedef struct {
    logic                              kind;
    logic                              sensor_valid;
    logic                              recenter_press;
    logic signed [toa_pkg::AXIS_W-1:0] axis[9];
  } frame_t;

  typedef struct {
    logic signed [toa_pkg::AIM_W-1:0] aim_h;
    logic signed [toa_pkg::AIM_W-1:0] aim_v;
    logic                             started;
  } aim_t;

  class aim_scoreboard;
    aim_t    pending_aim[$];
    int      errors;
    longint  ref_mat[9];
    bit      ref_ok;
    bit      in_recenter;
    int      wait_cnt;
    int      lock_cnt;
    longint  hold_h;
    longint  hold_v;
    bit      hold_s;
    int      wait_frames;
    int      lock_frames;
    int      yaw_rng;
    int      pitch_rng;
    longint  atan_lut[24];

    function new();
      atan_lut = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                   16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                   131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                   127};
      foreach (ref_mat[i]) ref_mat[i] = 0;
      ref_ok = 0; in_recenter = 0; wait_cnt = 0; lock_cnt = 0;
      hold_h = 0; hold_v = 0; hold_s = 0; errors = 0;
      wait_frames = 60; lock_frames = 60; yaw_rng = 6434; pitch_rng = 6434;
    endfunction

    function void set_reg(logic [toa_pkg::CFG_IDX_W-1:0] idx, int val);
      case (idx)
        toa_pkg::CFG_WAIT_FRAMES:    wait_frames = val & 'h3FF;
        toa_pkg::CFG_LOCKOUT_FRAMES: lock_frames = val & 'h3FF;
        toa_pkg::CFG_YAW_RANGE:      yaw_rng = val & 'h7FFF;
        default:                     pitch_rng = val & 'h7FFF;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < toa_pkg::ATAN_ITER_DEF && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_lut[i];
        end else begin
          x -= dx; y += dy; z -= atan_lut[i];
        end
      end
      return z;
    endfunction

    function longint deflection(longint a, int rng);
      longint mag, d, q;
      mag = a < 0 ? -a : a;
      d = longint'(rng == 0 ? 1 : rng) << 17;
      q = ((mag << toa_pkg::FRAC_BITS_DEF) + d / 2) / d;
      if (q > (64'sd1 << toa_pkg::FRAC_BITS_DEF)) q = 64'sd1 << toa_pkg::FRAC_BITS_DEF;
      return a > 0 ? -q : q;
    endfunction

    function longint unit_comp(longint c, longint unsigned r);
      longint unsigned mag, q;
      mag = c < 0 ? -c : c;
      q = ((mag << (toa_pkg::FRAC_BITS_DEF + 8)) + r / 2) / r;
      return c < 0 ? -longint'(q) : longint'(q);
    endfunction

    function void note_input(frame_t f);
      longint p[3], s, pitch, yaw, ah, av;
      longint unsigned l2, rr;
      aim_t e;
      bit calc;
      if (f.kind == toa_pkg::KIND_CAPTURE) begin
        foreach (ref_mat[i]) ref_mat[i] = f.axis[i];
        ref_ok = 1;
      end else if (f.sensor_valid && ref_ok) begin
        calc = 1;
        hold_s = 0;
        if (lock_cnt > 0) lock_cnt--;
        if (!in_recenter && lock_cnt == 0 && f.recenter_press) begin
          in_recenter = 1;
          wait_cnt = 0;
          hold_s = 1;
        end
        if (in_recenter) begin
          wait_cnt = (wait_cnt + 1) & 'h7FF;
          if (wait_cnt > wait_frames) begin
            foreach (ref_mat[i]) ref_mat[i] = f.axis[i];
            in_recenter = 0;
            lock_cnt = lock_frames;
          end else begin
            hold_h = 0;
            hold_v = 0;
            calc = 0;
          end
        end
        if (calc) begin
          for (int r = 0; r < 3; r++) begin
            s = 0;
            for (int c = 0; c < 3; c++) s += ref_mat[r*3+c] * longint'(f.axis[6+c]);
            p[r] = s >>> 6;
          end
          pitch = vector_angle(-p[1], p[2]);
          yaw = vector_angle(p[0], longint'(int_sqrt(p[1]*p[1] + p[2]*p[2])));
          ah = deflection(yaw, yaw_rng);
          av = deflection(pitch, pitch_rng);
          l2 = ah*ah + av*av;
          if (l2 > (64'd1 << (2*toa_pkg::FRAC_BITS_DEF))) begin
            rr = int_sqrt(l2 << 16);
            ah = unit_comp(ah, rr);
            av = unit_comp(av, rr);
          end
          hold_h = ah;
          hold_v = av;
        end
      end
      e.aim_h = hold_h[toa_pkg::AIM_W-1:0];
      e.aim_v = hold_v[toa_pkg::AIM_W-1:0];
      e.started = hold_s;
      pending_aim.push_back(e);
    endfunction

    function void check_result(aim_t got);
      aim_t e;
      if (pending_aim.size() == 0) begin
        $error("unexpected result h=%0d v=%0d", got.aim_h, got.aim_v);
        errors++;
        return;
      end
      e = pending_aim.pop_front();
      if (got.aim_h !== e.aim_h) begin
        $error("aim_horizontal expected %0d actual %0d", e.aim_h, got.aim_h);
        errors++;
      end
      if (got.aim_v !== e.aim_v) begin
        $error("aim_vertical expected %0d actual %0d", e.aim_v, got.aim_v);
        errors++;
      end
      if (got.started !== e.started) begin
        $error("recenter_started expected %0d actual %0d", e.started, got.started);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [toa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [toa_pkg::CFG_W-1:0] cfg_data;
  bit idle_on = 1;
  bit hold_off = 0;
  bit hold_done = 0;

  aim_scoreboard sb = new();

  toa_in_if  in_ch();
  toa_out_if out_ch();

  tilt_orientation_to_aim_top DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    frame_t f;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      f.kind = in_ch.kind;
      f.sensor_valid = in_ch.sensor_valid;
      f.recenter_press = in_ch.recenter_press;
      f.axis = '{in_ch.axis_x_x, in_ch.axis_x_y, in_ch.axis_x_z,
                 in_ch.axis_y_x, in_ch.axis_y_y, in_ch.axis_y_z,
                 in_ch.axis_z_x, in_ch.axis_z_y, in_ch.axis_z_z};
      sb.note_input(f);
    end
  end

  always @(posedge clk) begin
    aim_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a.aim_h = out_ch.aim_horizontal;
      a.aim_v = out_ch.aim_vertical;
      a.started = out_ch.recenter_started;
      sb.check_result(a);
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (800) @(posedge clk);
        hold_done = 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_frame(frame_t f);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= f.kind;
    in_ch.sensor_valid <= f.sensor_valid;
    in_ch.recenter_press <= f.recenter_press;
    in_ch.axis_x_x <= f.axis[0]; in_ch.axis_x_y <= f.axis[1];
    in_ch.axis_x_z <= f.axis[2]; in_ch.axis_y_x <= f.axis[3];
    in_ch.axis_y_y <= f.axis[4]; in_ch.axis_y_z <= f.axis[5];
    in_ch.axis_z_x <= f.axis[6]; in_ch.axis_z_y <= f.axis[7];
    in_ch.axis_z_z <= f.axis[8];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_axes(int kind, int sv, int press,
                           int xx, int xy, int xz, int yx, int yy, int yz,
                           int zx, int zy, int zz);
    frame_t f;
    f.kind = kind[0];
    f.sensor_valid = sv[0];
    f.recenter_press = press[0];
    f.axis = '{toa_pkg::AXIS_W'(xx), toa_pkg::AXIS_W'(xy), toa_pkg::AXIS_W'(xz),
               toa_pkg::AXIS_W'(yx), toa_pkg::AXIS_W'(yy), toa_pkg::AXIS_W'(yz),
               toa_pkg::AXIS_W'(zx), toa_pkg::AXIS_W'(zy), toa_pkg::AXIS_W'(zz)};
    send_frame(f);
  endtask

  task automatic drain_and_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_aim.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [toa_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= toa_pkg::CFG_W'(val);
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int rand_comp();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return -16384;
    if (sel == 1) return 16384;
    if (sel == 2) return 0;
    if (sel < 6) return $urandom_range(0, 32768) - 16384;
    return $urandom_range(0, 4000) - 2000;
  endfunction

  task automatic random_phase(int count);
    frame_t f;
    int base;
    for (int n = 0; n < count; n++) begin
      f.kind = ($urandom_range(0, 19) == 0) ? toa_pkg::KIND_CAPTURE : toa_pkg::KIND_FRAME;
      f.sensor_valid = ($urandom_range(0, 9) != 0);
      f.recenter_press = ($urandom_range(0, 6) == 0);
      for (int i = 0; i < 9; i++) f.axis[i] = toa_pkg::AXIS_W'(rand_comp());
      if ($urandom_range(0, 2) != 0) begin
        for (int i = 0; i < 9; i++) begin
          base = (i % 4 == 0) ? 16000 : 0;
          f.axis[i] = toa_pkg::AXIS_W'(base + $urandom_range(0, 6000) - 3000);
        end
      end
      send_frame(f);
    end
  endtask

  task automatic set_all(int w, int l, int y, int p);
    write_reg(toa_pkg::CFG_WAIT_FRAMES, w);
    write_reg(toa_pkg::CFG_LOCKOUT_FRAMES, l);
    write_reg(toa_pkg::CFG_YAW_RANGE, y);
    write_reg(toa_pkg::CFG_PITCH_RANGE, p);
  endtask

  initial begin
    cfg_we <= 1'b0;
    cfg_index <= toa_pkg::CFG_WAIT_FRAMES;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= toa_pkg::KIND_FRAME;
    in_ch.sensor_valid <= 1'b0;
    in_ch.recenter_press <= 1'b0;
    in_ch.axis_x_x <= '0; in_ch.axis_x_y <= '0; in_ch.axis_x_z <= '0;
    in_ch.axis_y_x <= '0; in_ch.axis_y_y <= '0; in_ch.axis_y_z <= '0;
    in_ch.axis_z_x <= '0; in_ch.axis_z_y <= '0; in_ch.axis_z_z <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no reference yet, then identity reference
    send_axes(toa_pkg::KIND_FRAME, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 16384);
    send_axes(toa_pkg::KIND_CAPTURE, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, 0, 16384, 0, 0);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, 0, -16384, 0, 0);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, 0, 0, -16384, 0);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, -16384);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, 0, 0, 3000, -16384);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, 0, 0, -3000, -16384);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, 0, 9000, -9000, 2000);
    send_axes(toa_pkg::KIND_FRAME, 0, 1, 0, 0, 0, 0, 0, 0, 16384, 0, 0);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, -16384, -16384, -16384, 16384, 16384, 16384,
              -16384, 16384, -16384);
    drain_and_idle();
    set_all(2, 3, 1, 25736);
    send_axes(toa_pkg::KIND_FRAME, 1, 1, 0, 0, 0, 0, 0, 0, 100, -200, 16384);
    send_axes(toa_pkg::KIND_FRAME, 1, 1, 0, 0, 0, 0, 0, 0, 100, -200, 16384);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, 0, 100, -200, 16384);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 16384, 0, 0, 0, 16384, 0, 500, 700, 16000);
    send_axes(toa_pkg::KIND_FRAME, 1, 1, 0, 0, 0, 0, 0, 0, 8000, 300, 14000);
    send_axes(toa_pkg::KIND_FRAME, 1, 0, 0, 0, 0, 0, 0, 0, 8000, 300, 14000);
    send_axes(toa_pkg::KIND_FRAME, 1, 1, 0, 0, 0, 0, 0, 0, 8000, 300, 14000);
    send_axes(toa_pkg::KIND_FRAME, 1, 1, 0, 0, 0, 0, 0, 0, 8000, 300, 14000);
    drain_and_idle();

    set_all(4, 6, 3000, 9000);
    send_axes(toa_pkg::KIND_CAPTURE, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    hold_off = 1;
    random_phase(90);
    drain_and_idle();

    set_all(0, 0, 25736, 1);
    random_phase(90);
    drain_and_idle();

    set_all(1023, 1023, 6434, 6434);
    random_phase(60);
    drain_and_idle();

    set_all(60, 60, 12000, 500);
    random_phase(90);
    drain_and_idle();

    set_all(3, 2, 800, 20000);
    idle_on = 0;
    random_phase(90);
    drain_and_idle();

    if (sb.errors == 0 && sb.pending_aim.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
